[design/btmx_pkg.sv]
// Shared constants, codes and types for the binary trie max-xor block.
`timescale 1ns / 1ps

package btmx_pkg;

    localparam int KEY_BITS_DEF  = 32;
    localparam int MAX_NODES_DEF = 8192;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REFUSED  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ANSWERED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOMATCH  = 2'd3;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] limit;
    } cmd_t;

endpackage

[design/btmx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module btmx_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/btmx_front.sv]
// Front end: accepts input beats into a two-entry command queue.
`timescale 1ns / 1ps

module btmx_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 op,
    input  logic [31:0]          key,
    input  logic [31:0]          limit,
    output logic                 cmd_valid,
    input  logic                 cmd_pop,
    output btmx_pkg::cmd_t       cmd
);

    localparam int QDEPTH = 2;

    btmx_pkg::cmd_t slot_reg [QDEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push_ok, pop_ok;
    btmx_pkg::cmd_t in_cmd;

    assign full      = (count_reg == 2'(QDEPTH));
    assign cmd_valid = (count_reg != 2'd0);
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_pop && cmd_valid;
    assign cmd       = slot_reg[rd_ptr_reg];

    // op is a single bit, so every code is a legal insert or query
    always_comb
    begin
        in_cmd.op    = (op == btmx_pkg::OP_QUERY) ? btmx_pkg::OP_QUERY : btmx_pkg::OP_INSERT;
        in_cmd.key   = key;
        in_cmd.limit = limit;
    end

    always_comb
    begin
        wr_ptr_next = push_ok ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push_ok) - 2'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("command queue count out of range");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok && !pop_ok |=> count_reg != 2'd0)
        else $error("command queue lost a pushed beat");

endmodule

[design/btmx_back.sv]
// Back end: trie walk engine over the child-link RAM, with the result register.
`timescale 1ns / 1ps

module btmx_back #(
    parameter int KEY_BITS  = btmx_pkg::KEY_BITS_DEF,
    parameter int MAX_NODES = btmx_pkg::MAX_NODES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  btmx_pkg::cmd_t                cmd,
    output logic                          empty,
    input  logic                          pop,
    output logic [btmx_pkg::STATUS_W-1:0] status,
    output logic [31:0]                   best_xor
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int LVL_W  = $clog2(KEY_BITS);
    localparam int LINK_W = 2 * NODE_W;

    localparam logic [LVL_W-1:0] TOP_LVL     = LVL_W'(KEY_BITS - 1);
    localparam logic [CNT_W-1:0] ALLOC_LIMIT = CNT_W'(MAX_NODES - KEY_BITS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_IWALK  = 3'd1;
    localparam logic [2:0] S_IALLOC = 3'd2;
    localparam logic [2:0] S_QWALK  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [LVL_W-1:0]              lvl_reg, lvl_next;
    logic [NODE_W-1:0]             node_reg, node_next;
    logic [CNT_W-1:0]              nf_reg, nf_next;
    logic [31:0]                   small_reg, small_next;
    logic [KEY_BITS-1:0]           key_reg, key_next;
    logic [31:0]                   key32_reg, key32_next;
    logic [KEY_BITS-1:0]           best_reg, best_next;
    logic [btmx_pkg::STATUS_W-1:0] pend_reg, pend_next;
    logic                          rd_root_reg, rd_root_next;
    logic                          root_valid_reg, root_valid_next;
    logic                          out_valid_reg, out_valid_next;
    logic [btmx_pkg::STATUS_W-1:0] out_status_reg;
    logic [31:0]                   out_best_reg;
    logic                          out_load;

    logic                          ram_we;
    logic [NODE_W-1:0]             ram_waddr, ram_raddr;
    logic [LINK_W-1:0]             ram_wdata, ram_rdata;

    logic [LINK_W-1:0]             entry;
    logic                          kb, last, refused, store_empty;
    logic [NODE_W-1:0]             child_same, child_opp, nf_node;

    btmx_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_NODES)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // root entry reads as empty until first written
    assign entry       = (rd_root_reg && !root_valid_reg) ? '0 : ram_rdata;
    assign kb          = key_reg[lvl_reg];
    assign child_same  = kb ? entry[LINK_W-1:NODE_W] : entry[NODE_W-1:0];
    assign child_opp   = kb ? entry[NODE_W-1:0] : entry[LINK_W-1:NODE_W];
    assign nf_node     = nf_reg[NODE_W-1:0];
    assign last        = (lvl_reg == '0);
    assign refused     = (nf_reg > ALLOC_LIMIT);
    assign store_empty = (nf_reg == CNT_W'(1));

    assign empty    = !out_valid_reg;
    assign status   = out_status_reg;
    assign best_xor = out_best_reg;

    always_comb
    begin
        state_next      = state_reg;
        lvl_next        = lvl_reg;
        node_next       = node_reg;
        nf_next         = nf_reg;
        small_next      = small_reg;
        key_next        = key_reg;
        key32_next      = key32_reg;
        best_next       = best_reg;
        pend_next       = pend_reg;
        cmd_pop         = 1'b0;
        out_load        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = node_reg;
        ram_wdata       = entry;
        ram_raddr       = node_reg;

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    key_next   = KEY_BITS'(cmd.key);
                    key32_next = cmd.key;
                    best_next  = '0;
                    lvl_next   = TOP_LVL;
                    node_next  = '0;
                    if (cmd.op == btmx_pkg::OP_INSERT)
                    begin
                        if (refused)
                        begin
                            pend_next  = btmx_pkg::STAT_REFUSED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_IWALK;
                        end
                    end
                    else
                    begin
                        if (store_empty || (small_reg > cmd.limit))
                        begin
                            pend_next  = btmx_pkg::STAT_NOMATCH;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_QWALK;
                        end
                    end
                end
            end
            S_IWALK:
            begin
                if (child_same != '0)
                begin
                    node_next = child_same;
                    ram_raddr = child_same;
                end
                else
                begin
                    // first missing child: hook a fresh node into this entry
                    ram_we    = 1'b1;
                    ram_wdata = kb ? {nf_node, entry[NODE_W-1:0]}
                                   : {entry[LINK_W-1:NODE_W], nf_node};
                    node_next = nf_node;
                    nf_next   = nf_reg + CNT_W'(1);
                    if (!last)
                    begin
                        state_next = S_IALLOC;
                    end
                end
                if (last)
                begin
                    small_next = (key32_reg < small_reg) ? key32_reg : small_reg;
                    pend_next  = btmx_pkg::STAT_INSERTED;
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            S_IALLOC:
            begin
                // fresh node: one child, written without a read
                ram_we    = 1'b1;
                ram_wdata = kb ? {nf_node, NODE_W'(0)} : {NODE_W'(0), nf_node};
                node_next = nf_node;
                nf_next   = nf_reg + CNT_W'(1);
                if (last)
                begin
                    small_next = (key32_reg < small_reg) ? key32_reg : small_reg;
                    pend_next  = btmx_pkg::STAT_INSERTED;
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            S_QWALK:
            begin
                if (child_opp != '0)
                begin
                    node_next          = child_opp;
                    ram_raddr          = child_opp;
                    best_next[lvl_reg] = 1'b1;
                end
                else
                begin
                    node_next = child_same;
                    ram_raddr = child_same;
                end
                if (last)
                begin
                    pend_next  = btmx_pkg::STAT_ANSWERED;
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_root_next    = (ram_raddr == '0);
        root_valid_next = root_valid_reg || (ram_we && (ram_waddr == '0));
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nf_reg         <= CNT_W'(1);
            small_reg      <= '1;
            rd_root_reg    <= 1'b0;
            root_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nf_reg         <= nf_next;
            small_reg      <= small_next;
            rd_root_reg    <= rd_root_next;
            root_valid_reg <= root_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg   <= lvl_next;
        node_reg  <= node_next;
        key_reg   <= key_next;
        key32_reg <= key32_next;
        best_reg  <= best_next;
        pend_reg  <= pend_next;
        if (out_load)
        begin
            out_status_reg <= pend_reg;
            out_best_reg   <= 32'(best_reg);
        end
    end

    a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= CNT_W'(MAX_NODES))
        else $error("node allocator ran past the link store");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IWALK || state_reg == S_IALLOC))
        else $error("link write outside an insert walk");

    a_refuse_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cmd_valid && cmd.op == btmx_pkg::OP_INSERT && refused)
        |=> (nf_reg == $past(nf_reg)))
        else $error("refused insert changed the allocator");

    a_query_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QWALK) |-> !store_empty)
        else $error("query walk on an empty store");

endmodule

[design/binary_trie_max_xor_top.sv]
// Top level of the binary trie max-xor block: command queue plus walk engine.
`timescale 1ns / 1ps
// Flow: an insert or answered query passes through the queue, dispatch, KEY_BITS walk
//   levels and the result load; refused inserts and no-match queries skip the walk.
// The engine finishes one item before it takes the next from the queue, paced by the one
//   dependent link-RAM read per trie level, and waits in DONE while a result is unpopped.
// Reset: asynchronous, active low. Clears queue, allocator (next node 1), smallest key
//   (all ones) and the root-valid flag; link RAM is not swept, no clearing pass.
module binary_trie_max_xor_top #(
    parameter int KEY_BITS  = btmx_pkg::KEY_BITS_DEF,
    parameter int MAX_NODES = btmx_pkg::MAX_NODES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input queue side: a beat is taken when push is high and full is low
    input  logic                          push,
    output logic                          full,
    input  logic                          op,
    input  logic [31:0]                   key,
    input  logic [31:0]                   limit,
    // result queue side: a beat is taken when pop is high and empty is low
    output logic                          empty,
    input  logic                          pop,
    output logic [btmx_pkg::STATUS_W-1:0] status,
    output logic [31:0]                   best_xor
);

    btmx_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    // front end: two-entry queue decouples the input side from the walk
    btmx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .key       (key),
        .limit     (limit),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // back end: one trie level per cycle through the child-link RAM; the result
    // register lets a finished beat wait while the engine keeps going
    btmx_back #(
        .KEY_BITS  (KEY_BITS),
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .status    (status),
        .best_xor  (best_xor)
    );

endmodule
